@@ src/olid_pkg.sv @@
// Shared types and codes for the ordered list insert/delete unit.
`default_nettype none
package olid_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  // index width covers the largest supported list
  localparam int IDX_W = 10;
  // leaves per first-level group of the read gather tree
  localparam int GROUP = 8;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] position;
    logic [7:0] element_in;
  } olid_in_t;

  typedef struct packed {
    logic [7:0] element_out;
    logic [1:0] status;
    logic [7:0] count;
    logic       is_empty;
    logic       is_full;
  } olid_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] pos;
    logic [7:0]       elem;
  } olid_ctl_t;

endpackage
`default_nettype wire

@@ src/olid_cell.sv @@
// One list slot: holds an entry and shifts toward either neighbor.
`default_nettype none
module olid_cell import olid_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic      clk,
  input  wire olid_ctl_t ctl,
  input  wire logic [7:0] left_i,
  input  wire logic [7:0] right_i,
  output logic [7:0]     data_o,
  output logic           sel_o
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;
  logic       at_pos;
  logic       above_pos;

  assign at_pos    = (32'(IDX) == 32'(ctl.pos));
  assign above_pos = (32'(IDX) > 32'(ctl.pos));

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (at_pos)
        data_nxt = ctl.elem;
      else if (above_pos)
        data_nxt = left_i;
    end else if (ctl.del) begin
      if (at_pos || above_pos)
        data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign sel_o  = at_pos;

endmodule
`default_nettype wire

@@ src/olid_gather.sv @@
// First level of the read tree: registered OR of selected entries per group.
`default_nettype none
module olid_gather import olid_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  wire logic                     clk,
  input  wire logic [CAPACITY-1:0][7:0] data_i,
  input  wire logic [CAPACITY-1:0]      sel_i,
  output logic [7:0]                    elem_o
);

  localparam int NG = (CAPACITY + GROUP - 1) / GROUP;

  logic [NG-1:0][7:0] grp_r;
  logic [NG-1:0][7:0] grp_nxt;

  always_comb begin
    grp_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          if (sel_i[g * GROUP + k])
            grp_nxt[g] = grp_nxt[g] | data_i[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  // second level is combinational here and registered by the caller
  always_comb begin
    elem_o = '0;
    for (int g = 0; g < NG; g++)
      elem_o = elem_o | grp_r[g];
  end

endmodule
`default_nettype wire

@@ src/ordered_list_insert_delete_unit.sv @@
// Ordered byte list with append, positional insert/delete and read.
// Each word updates the cells in S_EXEC while the first gather level samples the entries;
// the second gather level and the output register finish in S_SUM. No new word is taken
// while busy is high; busy drops in the cycle out_valid is shown.
// Reset: list count cleared to empty, no result pending; entry cells are not reset.
`default_nettype none
module ordered_list_insert_delete_unit import olid_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire olid_in_t in_data,
  output logic          out_valid,
  output olid_out_t     out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW : 8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  olid_in_t      cmd_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          hit_r, hit_nxt;
  logic          out_valid_r;
  olid_out_t     out_data_r;

  olid_ctl_t     ctl;
  logic [PW-1:0] pos_ext, cnt_ext, pos_eff;
  logic          is_full;
  logic [7:0]    gather_elem;

  logic [CAPACITY-1:0][7:0] cell_data;
  logic [CAPACITY-1:0]      cell_sel;

  assign pos_ext = PW'(cmd_r.position);
  assign cnt_ext = PW'(count_r);
  assign is_full = (count_r == CW'(CAPACITY));

  always_comb begin
    status_nxt = ST_OK;
    hit_nxt    = 1'b0;
    count_nxt  = count_r;
    ctl.ins    = 1'b0;
    ctl.del    = 1'b0;
    ctl.elem   = cmd_r.element_in;
    pos_eff    = (cmd_r.operation == OP_APPEND) ? cnt_ext : pos_ext;
    ctl.pos    = IDX_W'(pos_eff);
    if (cmd_r.operation == OP_APPEND || cmd_r.operation == OP_INSERT) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else if (pos_eff > cnt_ext) begin
        status_nxt = ST_BADPOS;
      end else begin
        ctl.ins   = (state_r == S_EXEC);
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (pos_ext >= cnt_ext) begin
        status_nxt = ST_BADPOS;
      end else begin
        hit_nxt = 1'b1;
        if (cmd_r.operation == OP_DELETE) begin
          ctl.del   = (state_r == S_EXEC);
          count_nxt = count_r - CW'(1);
        end
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [7:0] left_w, right_w;
      if (gi == 0) begin : g_first
        assign left_w = 8'h00;
      end else begin : g_mid_l
        assign left_w = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_w = 8'h00;
      end else begin : g_mid_r
        assign right_w = cell_data[gi+1];
      end
      olid_cell #(.IDX(gi)) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .left_i  (left_w),
        .right_i (right_w),
        .data_o  (cell_data[gi]),
        .sel_o   (cell_sel[gi])
      );
    end
  endgenerate

  // tree samples pre-shift contents at the same edge the cells update
  olid_gather #(.CAPACITY(CAPACITY)) u_gather (
    .clk    (clk),
    .data_i (cell_data),
    .sel_i  (cell_sel),
    .elem_o (gather_elem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_SUM);
      if (state_r == S_EXEC)
        count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start)
      cmd_r <= in_data;
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      hit_r    <= hit_nxt;
    end
    if (state_r == S_SUM) begin
      out_data_r.element_out <= hit_r ? gather_elem : 8'h00;
      out_data_r.status      <= status_r;
      out_data_r.count       <= 8'(count_r);
      out_data_r.is_empty    <= (count_r == '0);
      out_data_r.is_full     <= is_full;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ tb/tb_ordered_list_insert_delete_unit.sv @@
// Self-checking testbench for the ordered list insert/delete unit.
module tb_ordered_list_insert_delete_unit;
  import olid_pkg::*;

  localparam int CAPACITY = 128;
  // cycles with no word moving in either direction before the run is abandoned
  localparam int STALL_LIMIT = 500;
  localparam int BIAS_GROW = 0;
  localparam int BIAS_SHRINK = 1;
  localparam int BIAS_EVEN = 2;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  olid_in_t  in_data;
  logic      out_valid;
  olid_out_t out_data;

  // shadow copy of the list
  logic [7:0] list_mem [CAPACITY];
  int         list_len = 0;

  olid_out_t  pending_results [$];
  int         mismatches = 0;
  int         stall_cycles = 0;

  ordered_list_insert_delete_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one operation to the shadow list and returns the result word it must produce.
  function automatic olid_out_t apply_list_op(olid_in_t w);
    olid_out_t r;
    int        p;
    r = '0;
    r.status = ST_OK;
    p = int'(w.position);
    if (w.operation == OP_APPEND || w.operation == OP_INSERT) begin
      // full check wins over the position check
      if (list_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        if (w.operation == OP_APPEND) p = list_len;
        if (p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = w.element_in;
          list_len++;
        end
      end
    end else begin
      if (p >= list_len) begin
        r.status = ST_BADPOS;
      end else begin
        r.element_out = list_mem[p];
        if (w.operation == OP_DELETE) begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
    end
    r.count    = 8'(list_len);
    r.is_empty = (list_len == 0);
    r.is_full  = (list_len == CAPACITY);
    return r;
  endfunction

  function automatic olid_in_t make_word(logic [1:0] op, logic [7:0] pos, logic [7:0] elem);
    olid_in_t w;
    w.operation  = op;
    w.position   = pos;
    w.element_in = elem;
    return w;
  endfunction

  task automatic check_field(string fname, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", fname, expv, actv);
      mismatches++;
    end
  endtask

  // Result checker and watchdog.
  always @(posedge clk) begin : check_results
    olid_out_t exp_w;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        exp_w = pending_results.pop_front();
        check_field("element_out", exp_w.element_out, out_data.element_out);
        check_field("status", 8'(exp_w.status), 8'(out_data.status));
        check_field("count", exp_w.count, out_data.count);
        check_field("is_empty", 8'(exp_w.is_empty), 8'(out_data.is_empty));
        check_field("is_full", 8'(exp_w.is_full), 8'(out_data.is_full));
      end
    end
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sends one word, with an optional random gap first; start stays high afterwards.
  task automatic send_word(olid_in_t w, int idle_pct);
    int gap;
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      gap = $urandom_range(6, 1);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_list_op(w));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_word(make_word(OP_READ, 8'd0, 8'h00), 0);
    send_word(make_word(OP_DELETE, 8'd255, 8'hFF), 0);
    send_word(make_word(OP_INSERT, 8'd1, 8'h5A), 0);
    send_word(make_word(OP_INSERT, 8'd0, 8'hFF), 0);
    send_word(make_word(OP_READ, 8'd0, 8'h00), 0);
    send_word(make_word(OP_DELETE, 8'd0, 8'h00), 0);
    send_word(make_word(OP_READ, 8'd0, 8'h00), 0);
  endtask

  task automatic test_shift_order();
    send_word(make_word(OP_APPEND, 8'd200, 8'h00), 0);
    send_word(make_word(OP_APPEND, 8'd0, 8'hA5), 0);
    // insert at the count acts as append
    send_word(make_word(OP_INSERT, 8'd2, 8'h3C), 0);
    send_word(make_word(OP_INSERT, 8'd1, 8'h81), 0);
    send_word(make_word(OP_INSERT, 8'd0, 8'h7E), 0);
    send_word(make_word(OP_INSERT, 8'd6, 8'h11), 0);
    for (int i = 0; i < 6; i++) send_word(make_word(OP_READ, 8'(i), 8'h00), 0);
    send_word(make_word(OP_READ, 8'd255, 8'h00), 0);
    send_word(make_word(OP_DELETE, 8'd2, 8'h00), 0);
    send_word(make_word(OP_DELETE, 8'd3, 8'h00), 0);
    send_word(make_word(OP_DELETE, 8'd0, 8'h00), 0);
    send_word(make_word(OP_READ, 8'd0, 8'h00), 0);
    send_word(make_word(OP_READ, 8'd1, 8'h00), 0);
  endtask

  task automatic test_full_list();
    while (list_len < CAPACITY) begin
      if ($urandom_range(3, 0) == 0)
        send_word(make_word(OP_INSERT, 8'($urandom_range(list_len, 0)),
                            8'($urandom_range(255, 0))), 0);
      else
        send_word(make_word(OP_APPEND, 8'($urandom_range(255, 0)),
                            8'($urandom_range(255, 0))), 0);
    end
    send_word(make_word(OP_APPEND, 8'd0, 8'h42), 0);
    send_word(make_word(OP_INSERT, 8'd200, 8'h42), 0);
    send_word(make_word(OP_INSERT, 8'd5, 8'h42), 0);
    send_word(make_word(OP_READ, 8'(CAPACITY - 1), 8'h00), 0);
    send_word(make_word(OP_READ, 8'(CAPACITY), 8'h00), 0);
    send_word(make_word(OP_DELETE, 8'(CAPACITY - 1), 8'h00), 0);
    send_word(make_word(OP_INSERT, 8'(CAPACITY - 1), 8'hC3), 0);
    send_word(make_word(OP_DELETE, 8'd0, 8'h00), 0);
    send_word(make_word(OP_INSERT, 8'd0, 8'h99), 0);
    while (list_len > 0) begin
      if ($urandom_range(2, 0) == 0)
        send_word(make_word(OP_READ, 8'($urandom_range(list_len - 1, 0)), 8'h00), 0);
      send_word(make_word(OP_DELETE, 8'($urandom_range(list_len - 1, 0)), 8'h00), 0);
    end
  endtask

  // Random traffic in segments that push the list toward full, toward empty, or neither.
  task automatic test_random_traffic(int n_words, int idle_pct);
    int         bias;
    int         seg_left;
    int         r;
    logic [1:0] op;
    olid_in_t   w;
    seg_left = 0;
    bias = BIAS_EVEN;
    for (int k = 0; k < n_words; k++) begin
      if (seg_left == 0) begin
        bias = $urandom_range(2, 0);
        seg_left = $urandom_range(150, 20);
      end
      seg_left--;
      r = $urandom_range(99, 0);
      case (bias)
        BIAS_GROW:   op = (r < 35) ? OP_APPEND : (r < 70) ? OP_INSERT :
                          (r < 85) ? OP_DELETE : OP_READ;
        BIAS_SHRINK: op = (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT :
                          (r < 75) ? OP_DELETE : OP_READ;
        default:     op = (r < 25) ? OP_APPEND : (r < 50) ? OP_INSERT :
                          (r < 75) ? OP_DELETE : OP_READ;
      endcase
      w.operation  = op;
      w.element_in = 8'($urandom_range(255, 0));
      if (op == OP_APPEND || $urandom_range(99, 0) < 12)
        w.position = 8'($urandom_range(255, 0));
      else if (op == OP_INSERT)
        w.position = 8'($urandom_range(list_len, 0));
      else
        w.position = (list_len == 0) ? 8'd0 : 8'($urandom_range(list_len - 1, 0));
      send_word(w, idle_pct);
      if ($urandom_range(99, 0) < 2) wait_for_results();
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_shift_order();
    wait_for_results();
    test_full_list();
    wait_for_results();
    test_random_traffic(580, 0);
    wait_for_results();
    test_random_traffic(580, 64);
    wait_for_results();
    test_random_traffic(580, 25);

    wait_for_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
